// ===== rtl/ufmr_pkg.sv =====
// Shared types and constants for the union-find engine with minimum-index roots.
// Used by ufmr_ctrl and union_find_min_root; depends on nothing else.
package ufmr_pkg;

    // Field widths fixed by the item format
    localparam int AGENT_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int OPCODE_W = 2;

    // Agent indices are AGENT_W bits wide, so no more entries than this can be reached
    localparam int AGENT_SLOTS = 1 << AGENT_W;

    // Operation codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_MERGE = 2'd1,
        OP_FIND  = 2'd2,
        OP_SAME  = 2'd3
    } t_opcode;

    // Status codes
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_IDX = 1'b1;

    // One result transaction
    typedef struct packed {
        logic [AGENT_W-1:0] root_a;
        logic [AGENT_W-1:0] root_b;
        logic               same_group;
        logic               did_merge;
        logic [COUNT_W-1:0] group_count;
        logic               status;
    } t_result;

    // Memory access controls from the sequencer
    typedef struct packed {
        logic wr_en;
        logic clr;
    } t_mem_ctl;

endpackage

// ===== rtl/ufmr_parent_mem.sv =====
// Parent pointer store: synchronous RAM with one read and one write port,
// per-entry valid bits that make an unwritten entry read as its own index.
// Depends on nothing else.
module ufmr_parent_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [AW-1:0] i_wr_data,
    input  logic          i_clr,
    input  logic [8:0]    i_active,
    output logic [AW-1:0] o_parent
);

    logic [AW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [AW-1:0]    r_rdata;
    logic [AW-1:0]    r_raddr;
    logic             r_rvld;
    logic             w_fwd;

    // Same-address write and read in the same cycle returns the new data
    assign w_fwd = i_wr_en && (i_wr_addr == i_rd_addr);

    // Write and registered read of the pointer array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= w_fwd ? i_wr_data : r_mem[i_rd_addr];
        r_raddr <= i_rd_addr;
    end

    // Valid bits: drop the active range on clear, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rvld  <= 1'b0;
        end else begin
            if (i_clr) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (9'(i) < i_active) begin
                        r_valid[i] <= 1'b0;
                    end
                end
            end
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rvld <= w_fwd || r_valid[i_rd_addr];
        end
    end

    // An entry never written since clear is its own root
    assign o_parent = r_rvld ? r_rdata : r_raddr;

endmodule

// ===== rtl/ufmr_ctrl.sv =====
// Operation sequencer: walks parent chains through the pointer memory,
// compresses paths, links roots and holds the result register.
// Depends on ufmr_pkg.
module ufmr_ctrl #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ufmr_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [ufmr_pkg::AGENT_W-1:0]      i_agent_a,
    input  logic [ufmr_pkg::AGENT_W-1:0]      i_agent_b,
    input  logic [ufmr_pkg::COUNT_W-1:0]      i_active,
    output ufmr_pkg::t_result                 o_res,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic [AW-1:0]                     o_rd_addr,
    output logic [AW-1:0]                     o_wr_addr,
    output logic [AW-1:0]                     o_wr_data,
    output ufmr_pkg::t_mem_ctl                o_mem_ctl,
    input  logic [AW-1:0]                     i_parent
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND_A,
        ST_COMP_A,
        ST_FIND_B,
        ST_COMP_B,
        ST_LINK,
        ST_RESP
    } t_state;

    t_state                           r_state,  n_state;
    ufmr_pkg::t_opcode                r_op,     n_op;
    logic [AW-1:0]                    r_a,      n_a;
    logic [AW-1:0]                    r_b,      n_b;
    logic [AW-1:0]                    r_cur,    n_cur;
    logic [AW-1:0]                    r_root_a, n_root_a;
    logic [AW-1:0]                    r_root_b, n_root_b;
    logic [ufmr_pkg::COUNT_W-1:0]     r_groups, n_groups;
    ufmr_pkg::t_result                r_res,    n_res;
    ufmr_pkg::t_result                r_out,    n_out;
    logic                             r_out_valid, n_out_valid;

    logic                             w_a_done;
    logic                             w_b_done;
    logic                             w_err;
    logic                             w_same;
    logic [AW-1:0]                    w_lo;
    logic [AW-1:0]                    w_hi;
    logic [ufmr_pkg::COUNT_W-1:0]     w_grp_dec;
    ufmr_pkg::t_opcode                w_op_in;

    assign w_op_in   = ufmr_pkg::t_opcode'(i_opcode);
    assign w_err     = ({1'b0, i_agent_a} >= i_active) ||
                       ((w_op_in != ufmr_pkg::OP_FIND) && ({1'b0, i_agent_b} >= i_active));
    assign w_same    = (r_root_a == r_root_b);
    assign w_lo      = (r_root_a < r_root_b) ? r_root_a : r_root_b;
    assign w_hi      = (r_root_a < r_root_b) ? r_root_b : r_root_a;
    assign w_grp_dec = (r_groups != '0) ? (r_groups - 9'd1) : r_groups;

    // Next-state and datapath
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_cur       = r_cur;
        n_root_a    = r_root_a;
        n_root_b    = r_root_b;
        n_groups    = r_groups;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;
        o_rd_addr   = r_cur;
        o_wr_addr   = r_cur;
        o_wr_data   = r_root_a;
        o_mem_ctl   = '0;
        w_a_done    = 1'b0;
        w_b_done    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_rd_addr = AW'(i_agent_a);
                if (i_in_valid) begin
                    n_op = w_op_in;
                    n_a  = AW'(i_agent_a);
                    n_b  = AW'(i_agent_b);
                    if (w_op_in == ufmr_pkg::OP_CLEAR) begin
                        o_mem_ctl.clr     = 1'b1;
                        n_groups          = i_active;
                        n_res             = '0;
                        n_res.group_count = i_active;
                        n_res.status      = ufmr_pkg::STAT_OK;
                        n_state           = ST_RESP;
                    end else if (w_err) begin
                        n_res             = '0;
                        n_res.group_count = r_groups;
                        n_res.status      = ufmr_pkg::STAT_IDX;
                        n_state           = ST_RESP;
                    end else begin
                        n_cur   = AW'(i_agent_a);
                        n_state = ST_FIND_A;
                    end
                end
            end

            // Chase pointers of agent a until an entry points at itself
            ST_FIND_A: begin
                if (i_parent == r_cur) begin
                    n_root_a = r_cur;
                    if (r_cur == r_a) begin
                        w_a_done = 1'b1;
                    end else begin
                        o_rd_addr = r_a;
                        n_cur     = r_a;
                        n_state   = ST_COMP_A;
                    end
                end else begin
                    o_rd_addr = i_parent;
                    n_cur     = i_parent;
                end
            end

            // Point each node on a's path at its root
            ST_COMP_A: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr       = r_cur;
                o_wr_data       = r_root_a;
                if (i_parent == r_root_a) begin
                    w_a_done = 1'b1;
                end else begin
                    o_rd_addr = i_parent;
                    n_cur     = i_parent;
                end
            end

            ST_FIND_B: begin
                if (i_parent == r_cur) begin
                    n_root_b = r_cur;
                    if (r_cur == r_b) begin
                        w_b_done = 1'b1;
                    end else begin
                        o_rd_addr = r_b;
                        n_cur     = r_b;
                        n_state   = ST_COMP_B;
                    end
                end else begin
                    o_rd_addr = i_parent;
                    n_cur     = i_parent;
                end
            end

            ST_COMP_B: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr       = r_cur;
                o_wr_data       = r_root_b;
                if (i_parent == r_root_b) begin
                    w_b_done = 1'b1;
                end else begin
                    o_rd_addr = i_parent;
                    n_cur     = i_parent;
                end
            end

            // Build the result; on a merge of distinct roots, hang the larger root under the smaller one
            ST_LINK: begin
                n_res            = '0;
                n_res.status     = ufmr_pkg::STAT_OK;
                n_res.same_group = w_same;
                if ((r_op == ufmr_pkg::OP_MERGE) && !w_same) begin
                    o_mem_ctl.wr_en   = 1'b1;
                    o_wr_addr         = w_hi;
                    o_wr_data         = w_lo;
                    n_groups          = w_grp_dec;
                    n_res.root_a      = 8'(w_lo);
                    n_res.root_b      = 8'(w_lo);
                    n_res.did_merge   = 1'b1;
                    n_res.group_count = w_grp_dec;
                end else begin
                    n_res.root_a      = 8'(r_root_a);
                    n_res.root_b      = 8'(r_root_b);
                    n_res.group_count = r_groups;
                end
                n_state = ST_LINK == r_state ? ST_RESP : r_state;
            end

            // Load the output register once it is free
            ST_RESP: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Agent a resolved: finish a find, or start on agent b
        if (w_a_done) begin
            if (r_op == ufmr_pkg::OP_FIND) begin
                n_res             = '0;
                n_res.root_a      = 8'(n_root_a);
                n_res.group_count = r_groups;
                n_res.status      = ufmr_pkg::STAT_OK;
                n_state           = ST_RESP;
            end else begin
                o_rd_addr = r_b;
                n_cur     = r_b;
                n_state   = ST_FIND_B;
            end
        end

        if (w_b_done) begin
            n_state = ST_LINK;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_groups    <= ufmr_pkg::COUNT_W'(DEPTH);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_groups    <= n_groups;
            r_out_valid <= n_out_valid;
        end
        r_op     <= n_op;
        r_a      <= n_a;
        r_b      <= n_b;
        r_cur    <= n_cur;
        r_root_a <= n_root_a;
        r_root_b <= n_root_b;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

endmodule

// ===== rtl/union_find_min_root.sv =====
// Top level of the union-find engine: stream ports, agent-count register,
// pointer memory and sequencer. Depends on ufmr_pkg, ufmr_parent_mem, ufmr_ctrl.
//
//  Port group    Dir  Payload
//  ------------  ---  ---------------------------------------------------------
//  i_s_axis_*    in   tuser: opcode; tdata: agent_a, agent_b
//  o_m_axis_*    out  tdata: root_a, root_b, same_group, did_merge, group_count;
//                     tuser: status
//  i_cfg_*       in   agents_in_use, written whenever i_cfg_wen is high
//
// One transaction is handled at a time; all cycles go to the single read port
// of the parent memory. Clear and index errors go from idle straight to the
// result stage. A find walks the chain of agent a, then compresses it; merge
// and query add the walk of agent b and a link step. Reset sets every entry
// to its own root through the valid bits, with no sweep. A full output
// register stalls the sequencer; input is taken only when idle.
module union_find_min_root #(
    parameter int MAX_AGENTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] agent_a, [15:8] agent_b
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] root_a, [15:8] root_b, [16] same_group,
                                          // [17] did_merge, [26:18] group_count, [31:27] zero
    output logic [0:0]  o_m_axis_tuser,   // [0] status
    input  logic        i_cfg_wen,
    input  logic [8:0]  i_cfg_wdata       // [8:0] agents_in_use
);

    localparam int DEPTH = (MAX_AGENTS < ufmr_pkg::AGENT_SLOTS) ?
                           MAX_AGENTS : ufmr_pkg::AGENT_SLOTS;
    localparam int AW    = $clog2(DEPTH);

    logic [ufmr_pkg::COUNT_W-1:0] r_agents, n_agents;
    logic [ufmr_pkg::COUNT_W-1:0] w_active;
    ufmr_pkg::t_result            w_res;
    ufmr_pkg::t_mem_ctl           w_mem_ctl;
    logic [AW-1:0]                w_rd_addr;
    logic [AW-1:0]                w_wr_addr;
    logic [AW-1:0]                w_wr_data;
    logic [AW-1:0]                w_parent;

    // Hold the agent-count register
    assign n_agents = i_cfg_wen ? i_cfg_wdata : r_agents;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agents <= ufmr_pkg::COUNT_W'(ufmr_pkg::AGENT_SLOTS);
        end else begin
            r_agents <= n_agents;
        end
    end

    // Clamp the count to MAX_AGENTS
    assign w_active = (17'(r_agents) > 17'(MAX_AGENTS)) ?
                      ufmr_pkg::COUNT_W'(MAX_AGENTS) : r_agents;

    ufmr_parent_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_mem_ctl.wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_clr     (w_mem_ctl.clr),
        .i_active  (w_active),
        .o_parent  (w_parent)
    );

    ufmr_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_opcode    (i_s_axis_tuser),
        .i_agent_a   (i_s_axis_tdata[7:0]),
        .i_agent_b   (i_s_axis_tdata[15:8]),
        .i_active    (w_active),
        .o_res       (w_res),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_rd_addr   (w_rd_addr),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_mem_ctl   (w_mem_ctl),
        .i_parent    (w_parent)
    );

    // Pack the result transaction
    assign o_m_axis_tdata = {5'd0, w_res.group_count, w_res.did_merge, w_res.same_group,
                             w_res.root_b, w_res.root_a};
    assign o_m_axis_tuser = w_res.status;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for union_find_min_root: drives clear, merge, find and same-group
// transactions under changing agent counts and checks every result against a parent table.
// Depends on ufmr_pkg and the union_find_min_root RTL.
module tb;

    // Shadow of the parent table and group counter; predicts one result per transaction
    class root_tracker;
        logic [ufmr_pkg::AGENT_W-1:0] parent [ufmr_pkg::AGENT_SLOTS];
        logic [ufmr_pkg::COUNT_W-1:0] groups_left;
        logic [8:0]                   agents_cfg;
        ufmr_pkg::t_result            pending_results [$];
        int                           mismatches;

        function new();
            agents_cfg  = 9'd256;
            groups_left = 9'd256;
            mismatches  = 0;
            for (int i = 0; i < ufmr_pkg::AGENT_SLOTS; i++) begin
                parent[i] = ufmr_pkg::AGENT_W'(i);
            end
        endfunction

        // Register values above the table size saturate
        function int unsigned in_use();
            return (agents_cfg > 9'd256) ? 256 : agents_cfg;
        endfunction

        // Walk to the root, then point every agent on the path straight at it
        function logic [ufmr_pkg::AGENT_W-1:0] trace_root(
            logic [ufmr_pkg::AGENT_W-1:0] start);
            logic [ufmr_pkg::AGENT_W-1:0] r;
            logic [ufmr_pkg::AGENT_W-1:0] x;
            logic [ufmr_pkg::AGENT_W-1:0] nx;
            r = start;
            while (parent[r] != r) r = parent[r];
            x = start;
            while (x != r) begin
                nx        = parent[x];
                parent[x] = r;
                x         = nx;
            end
            return r;
        endfunction

        function void note_request(ufmr_pkg::t_opcode op, logic [7:0] a, logic [7:0] b);
            ufmr_pkg::t_result res;
            int unsigned       n;
            logic [7:0]        lo;
            logic [7:0]        hi;
            n   = in_use();
            res = '0;
            if (op == ufmr_pkg::OP_CLEAR) begin
                for (int unsigned i = 0; i < n; i++) parent[i] = ufmr_pkg::AGENT_W'(i);
                groups_left = ufmr_pkg::COUNT_W'(n);
            end else if (a >= n || (op != ufmr_pkg::OP_FIND && b >= n)) begin
                res.status = ufmr_pkg::STAT_IDX;
            end else if (op == ufmr_pkg::OP_FIND) begin
                res.root_a = trace_root(a);
            end else begin
                res.root_a     = trace_root(a);
                res.root_b     = trace_root(b);
                res.same_group = (res.root_a == res.root_b);
                // Join distinct groups: the larger root points at the smaller one
                if (op == ufmr_pkg::OP_MERGE && !res.same_group) begin
                    lo = (res.root_a < res.root_b) ? res.root_a : res.root_b;
                    hi = (res.root_a < res.root_b) ? res.root_b : res.root_a;
                    parent[hi] = lo;
                    if (groups_left != 0) groups_left--;
                    res.did_merge = 1'b1;
                    res.root_a    = lo;
                    res.root_b    = lo;
                end
            end
            res.group_count = groups_left;
            pending_results.push_back(res);
        endfunction

        task flag_mismatch(string what, int got, int want);
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            mismatches++;
        endtask

        task check_response(logic [31:0] data, logic [0:0] stat);
            ufmr_pkg::t_result want;
            if (pending_results.size() == 0) begin
                flag_mismatch("tdata of a result with none pending", data, 0);
                return;
            end
            want = pending_results.pop_front();
            if (data[7:0] !== want.root_a) flag_mismatch("root_a", data[7:0], want.root_a);
            if (data[15:8] !== want.root_b) flag_mismatch("root_b", data[15:8], want.root_b);
            if (data[16] !== want.same_group)
                flag_mismatch("same_group", data[16], want.same_group);
            if (data[17] !== want.did_merge) flag_mismatch("did_merge", data[17], want.did_merge);
            if (data[26:18] !== want.group_count)
                flag_mismatch("group_count", data[26:18], want.group_count);
            if (data[31:27] !== 5'd0) flag_mismatch("tdata padding", data[31:27], 0);
            if (stat !== want.status) flag_mismatch("status", stat, want.status);
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_wen   = 1'b0;
    logic [8:0]  cfg_wdata = '0;

    root_tracker tracker;
    bit          hold_request = 1'b0;   // ask the sink for one long hold-off
    bit          steady_flow  = 1'b0;   // no idling on either side

    always #10 clk = ~clk;

    union_find_min_root DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_wen       (cfg_wen),
        .i_cfg_wdata     (cfg_wdata)
    );

    // Offer one transaction, hold it until taken, then idle for a random gap
    task automatic offer(ufmr_pkg::t_opcode op, logic [7:0] a, logic [7:0] b);
        int pick;
        int len;
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= op;
        @(posedge clk);
        while (s_tready !== 1'b1) @(posedge clk);
        tracker.note_request(op, a, b);
        pick = $urandom_range(0, 99);
        if (steady_flow || pick < 60) len = 0;
        else if (pick < 92) len = $urandom_range(1, 3);
        else len = $urandom_range(8, 40);
        if (len > 0) begin
            s_tvalid <= 1'b0;
            repeat (len) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every predicted result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the agent count while the block is idle
    task automatic set_agents(logic [8:0] value);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        tracker.agents_cfg = value;
    endtask

    // Mostly in-range indices, with some stray ones to hit the index error
    function automatic logic [7:0] pick_agent(int unsigned n);
        if (n == 0 || $urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, n - 1));
    endfunction

    function automatic ufmr_pkg::t_opcode pick_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) return ufmr_pkg::OP_CLEAR;
        if (pick < 45) return ufmr_pkg::OP_MERGE;
        if (pick < 75) return ufmr_pkg::OP_FIND;
        return ufmr_pkg::OP_SAME;
    endfunction

    // Result sink: check each transaction, then pick the next ready value
    initial begin : sink
        int stall_left;
        int pick;
        stall_left = 0;
        @(posedge clk iff rst_n);
        forever begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready) tracker.check_response(m_tdata, m_tuser);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (steady_flow) begin
                m_tready <= 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    stall_left = (pick < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    initial begin : stimulus
        logic [8:0]  phase_cfg [12];
        int unsigned n;
        tracker   = new();
        phase_cfg = '{9'd16, 9'd1, 9'd2, 9'd256, 9'd7, 9'd0, 9'd40, 9'd511, 9'd5, 9'd128,
                      9'd23, 9'd256};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Table extremes after reset
        offer(ufmr_pkg::OP_FIND, 8'd0, 8'd255);
        offer(ufmr_pkg::OP_FIND, 8'd255, 8'd255);
        offer(ufmr_pkg::OP_SAME, 8'd0, 8'd255);
        offer(ufmr_pkg::OP_MERGE, 8'd255, 8'd0);
        offer(ufmr_pkg::OP_MERGE, 8'd254, 8'd255);
        offer(ufmr_pkg::OP_FIND, 8'd254, 8'd0);
        // Build a three-link chain, walk and compress it, then merge within one group
        offer(ufmr_pkg::OP_MERGE, 8'd10, 8'd11);
        offer(ufmr_pkg::OP_MERGE, 8'd9, 8'd10);
        offer(ufmr_pkg::OP_MERGE, 8'd8, 8'd9);
        offer(ufmr_pkg::OP_FIND, 8'd11, 8'd255);
        offer(ufmr_pkg::OP_SAME, 8'd11, 8'd8);
        offer(ufmr_pkg::OP_MERGE, 8'd11, 8'd8);
        offer(ufmr_pkg::OP_CLEAR, 8'hff, 8'hff);

        // Index errors with three agents; find ignores agent_b
        set_agents(9'd3);
        offer(ufmr_pkg::OP_MERGE, 8'd5, 8'd0);
        offer(ufmr_pkg::OP_SAME, 8'd0, 8'd3);
        offer(ufmr_pkg::OP_FIND, 8'd2, 8'd200);
        offer(ufmr_pkg::OP_CLEAR, 8'd0, 8'd0);
        offer(ufmr_pkg::OP_MERGE, 8'd0, 8'd1);
        offer(ufmr_pkg::OP_MERGE, 8'd2, 8'd1);

        // Widen without a clear so merges drive the count to its floor
        set_agents(9'd256);
        offer(ufmr_pkg::OP_MERGE, 8'd200, 8'd201);
        offer(ufmr_pkg::OP_MERGE, 8'd100, 8'd101);

        // Nothing in use: every operation but clear returns an index error
        set_agents(9'd0);
        offer(ufmr_pkg::OP_FIND, 8'd0, 8'd0);
        offer(ufmr_pkg::OP_CLEAR, 8'd0, 8'd0);
        offer(ufmr_pkg::OP_MERGE, 8'd0, 8'd0);

        // Random phases, each under its own agent count
        foreach (phase_cfg[p]) begin
            set_agents(phase_cfg[p]);
            steady_flow = (p % 4 == 2);
            if ($urandom_range(0, 4) != 0) begin
                offer(ufmr_pkg::OP_CLEAR, 8'($urandom), 8'($urandom));
            end
            if (p == 3) hold_request = 1'b1;
            for (int k = 0; k < 130; k++) begin
                n = tracker.in_use();
                offer(pick_op(), pick_agent(n), pick_agent(n));
                if ($urandom_range(0, 99) == 0) drain();
            end
        end
        steady_flow = 1'b0;

        drain();
        repeat (16) @(posedge clk);
        if (tracker.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #200ms;
        $display("tb: failure");
        $finish;
    end

endmodule
